>>> design/rpy_pkg.sv
// ----------------------------------------------------------------------------
// rpy_pkg
// shared types and constants for the rgb pair to yuyv converter
// ----------------------------------------------------------------------------
package rpy_pkg;

    localparam int LANES = 2;

    localparam int COEF_Y_R = 66;
    localparam int COEF_Y_G = 129;
    localparam int COEF_Y_B = 25;
    localparam int COEF_U_R = 38;
    localparam int COEF_U_G = 74;
    localparam int COEF_U_B = 112;
    localparam int COEF_V_R = 112;
    localparam int COEF_V_G = 94;
    localparam int COEF_V_B = 18;
    localparam int ROUND_BIAS = 128;
    localparam int LUMA_OFFSET = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int PIX_MAX = 255;

    typedef logic [7:0] pix8_t;

    typedef struct packed {
        pix8_t red;
        pix8_t green;
        pix8_t blue;
    } pixel_t;

    typedef struct packed {
        pix8_t             luma_term;
        logic signed [7:0] u_term;
        logic signed [7:0] v_term;
    } lane_result_t;

    typedef struct packed {
        pix8_t luma_first;
        pix8_t chroma_blue;
        pix8_t luma_second;
        pix8_t chroma_red;
    } yuyv_t;

endpackage

>>> design/rpy_if.sv
// ----------------------------------------------------------------------------
// rpy interfaces
// valid/ready channels for rgb pixel pairs and yuyv groups
// ----------------------------------------------------------------------------
interface rpy_pair_if;
    logic                 valid;
    logic                 ready;
    rpy_pkg::pix8_t       red_first;
    rpy_pkg::pix8_t       green_first;
    rpy_pkg::pix8_t       blue_first;
    rpy_pkg::pix8_t       red_second;
    rpy_pkg::pix8_t       green_second;
    rpy_pkg::pix8_t       blue_second;

    modport source (
        output valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second,
        input  ready
    );
    modport sink (
        input  valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second,
        output ready
    );
endinterface

interface rpy_group_if;
    logic                 valid;
    logic                 ready;
    rpy_pkg::pix8_t       luma_first;
    rpy_pkg::pix8_t       chroma_blue;
    rpy_pkg::pix8_t       luma_second;
    rpy_pkg::pix8_t       chroma_red;

    modport source (
        output valid, luma_first, chroma_blue, luma_second, chroma_red,
        input  ready
    );
    modport sink (
        input  valid, luma_first, chroma_blue, luma_second, chroma_red,
        output ready
    );
endinterface

>>> design/rgb_pair_to_yuyv.sv
// ----------------------------------------------------------------------------
// rgb_pair_to_yuyv
// converts a pair of adjacent rgb pixels to one yuyv 4:2:2 group
// ----------------------------------------------------------------------------
// One pixel pair is accepted every clock unless intake is stalled; its
// yuyv group passes two registers: the first holds each pixel's luma, u and v
// terms from two parallel lanes, the second holds the merged, averaged and
// clipped group. Both stages advance independently, so a stalled output only
// stops intake once both stages are full.
module rgb_pair_to_yuyv (
    input  logic      clk,
    input  logic      rst_n,
    rpy_pair_if.sink  pair,
    rpy_group_if.source yuyv
);

    rpy_pkg::pixel_t       lane_pixel [rpy_pkg::LANES];
    rpy_pkg::lane_result_t lane_result [rpy_pkg::LANES];
    rpy_pkg::yuyv_t        group;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  s1_en;
    logic                  out_en;

    assign lane_pixel[0] = '{red: pair.red_first, green: pair.green_first,
                             blue: pair.blue_first};
    assign lane_pixel[1] = '{red: pair.red_second, green: pair.green_second,
                             blue: pair.blue_second};

    assign out_en = !out_valid_reg || yuyv.ready;
    assign s1_en  = !s1_valid_reg || out_en;

    assign s1_valid_next  = s1_en ? pair.valid : s1_valid_reg;
    assign out_valid_next = out_en ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar i = 0; i < rpy_pkg::LANES; i++)
    begin : g_lane
        rpy_lane u_lane (
            .clk    (clk),
            .en     (s1_en),
            .pixel  (lane_pixel[i]),
            .result (lane_result[i])
        );
    end

    rpy_merge u_merge (
        .clk    (clk),
        .en     (out_en && s1_valid_reg),
        .lane_a (lane_result[0]),
        .lane_b (lane_result[1]),
        .group  (group)
    );

    assign pair.ready       = s1_en;
    assign yuyv.valid       = out_valid_reg;
    assign yuyv.luma_first  = group.luma_first;
    assign yuyv.chroma_blue = group.chroma_blue;
    assign yuyv.luma_second = group.luma_second;
    assign yuyv.chroma_red  = group.chroma_red;

    // an accepted transaction lands in the lane stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready) |=> s1_valid_reg)
        else $error("accepted transaction lost at lane stage");

    // intake stops only with both stages full and the output stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !pair.ready |-> (s1_valid_reg && out_valid_reg && !yuyv.ready))
        else $error("intake stalled without back pressure");

    // luma stays in studio range
    assert property (@(posedge clk) disable iff (!rst_n)
        yuyv.valid |-> (yuyv.luma_first >= 8'd16 && yuyv.luma_first <= 8'd235
                        && yuyv.luma_second >= 8'd16 && yuyv.luma_second <= 8'd235))
        else $error("luma out of studio range");

    // averaged chroma stays within offset plus or minus 112
    assert property (@(posedge clk) disable iff (!rst_n)
        yuyv.valid |-> (yuyv.chroma_blue >= 8'd16 && yuyv.chroma_blue <= 8'd240
                        && yuyv.chroma_red >= 8'd16 && yuyv.chroma_red <= 8'd240))
        else $error("chroma out of range");

endmodule

>>> design/rpy_lane.sv
// ----------------------------------------------------------------------------
// rpy_lane
// per-pixel core: registered luma, u and v terms of one rgb pixel
// ----------------------------------------------------------------------------
module rpy_lane (
    input  logic                  clk,
    input  logic                  en,
    input  rpy_pkg::pixel_t       pixel,
    output rpy_pkg::lane_result_t result
);

    logic [15:0]           r16;
    logic [15:0]           g16;
    logic [15:0]           b16;
    logic [15:0]           y_sum;
    logic [15:0]           u_sum;
    logic [15:0]           v_sum;
    rpy_pkg::lane_result_t result_reg;
    rpy_pkg::lane_result_t result_next;

    assign r16 = {8'd0, pixel.red};
    assign g16 = {8'd0, pixel.green};
    assign b16 = {8'd0, pixel.blue};

    // sums fit 16 bits, signed for u and v
    assign y_sum = 16'(rpy_pkg::COEF_Y_R * r16) + 16'(rpy_pkg::COEF_Y_G * g16)
                 + 16'(rpy_pkg::COEF_Y_B * b16) + 16'(rpy_pkg::ROUND_BIAS);
    assign u_sum = 16'(rpy_pkg::COEF_U_B * b16) - 16'(rpy_pkg::COEF_U_R * r16)
                 - 16'(rpy_pkg::COEF_U_G * g16) + 16'(rpy_pkg::ROUND_BIAS);
    assign v_sum = 16'(rpy_pkg::COEF_V_R * r16) - 16'(rpy_pkg::COEF_V_G * g16)
                 - 16'(rpy_pkg::COEF_V_B * b16) + 16'(rpy_pkg::ROUND_BIAS);

    // floor shift by 8 is the upper byte
    always_comb
    begin
        result_next.luma_term = y_sum[15:8];
        result_next.u_term    = $signed(u_sum[15:8]);
        result_next.v_term    = $signed(v_sum[15:8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> design/rpy_merge.sv
// ----------------------------------------------------------------------------
// rpy_merge
// combines the lane terms: luma offset, chroma averaging, clipping
// ----------------------------------------------------------------------------
module rpy_merge (
    input  logic                  clk,
    input  logic                  en,
    input  rpy_pkg::lane_result_t lane_a,
    input  rpy_pkg::lane_result_t lane_b,
    output rpy_pkg::yuyv_t        group
);

    logic signed [8:0] u_pair;
    logic signed [8:0] v_pair;
    logic signed [9:0] u_val;
    logic signed [9:0] v_val;
    rpy_pkg::yuyv_t    group_reg;
    rpy_pkg::yuyv_t    group_next;

    function automatic rpy_pkg::pix8_t clip8(input logic signed [9:0] v);
        rpy_pkg::pix8_t res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > 10'(rpy_pkg::PIX_MAX))
        begin
            res = 8'(rpy_pkg::PIX_MAX);
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    // halving truncates toward zero
    function automatic logic signed [9:0] half_offset(input logic signed [8:0] s);
        logic signed [9:0] adj;
        adj = 10'(s) + {9'd0, s[8]};
        return (adj >>> 1) + 10'(rpy_pkg::CHROMA_OFFSET);
    endfunction

    assign u_pair = 9'(lane_a.u_term) + 9'(lane_b.u_term);
    assign v_pair = 9'(lane_a.v_term) + 9'(lane_b.v_term);
    assign u_val  = half_offset(u_pair);
    assign v_val  = half_offset(v_pair);

    always_comb
    begin
        group_next.luma_first  = clip8($signed({2'b00, lane_a.luma_term})
                                       + 10'(rpy_pkg::LUMA_OFFSET));
        group_next.luma_second = clip8($signed({2'b00, lane_b.luma_term})
                                       + 10'(rpy_pkg::LUMA_OFFSET));
        group_next.chroma_blue = clip8(u_val);
        group_next.chroma_red  = clip8(v_val);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            group_reg <= group_next;
        end
    end

    assign group = group_reg;

endmodule
